/* rtl/trpt_pkg.sv */
// ----------------------------------------------------------------------------
// trpt_pkg
// Shared types, constants and pattern functions of the RAM pair pattern test.
// ----------------------------------------------------------------------------
package trpt_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int PATTERN_COUNT = 64;
  localparam int DATA_BITS     = 32;
  localparam int PIDX_BITS     = 7;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SAVE_BASE  = 3'd1,
    PH_SAVE_CELL  = 3'd2,
    PH_CHECK_BASE = 3'd3,
    PH_CHECK_CELL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic {
    REG_RAM_START = 1'b0,
    REG_RAM_END   = 1'b1
  } reg_index_t;

  // Background: zeros for walking-one patterns, ones for walking-zero ones.
  function automatic logic [DATA_BITS-1:0] background_word(input logic [PIDX_BITS-1:0] p);
    return (p < PIDX_BITS'(32)) ? '0 : '1;
  endfunction

  function automatic logic [DATA_BITS-1:0] pattern_word(input logic [PIDX_BITS-1:0] p);
    logic [DATA_BITS-1:0] bit_word;
    bit_word = DATA_BITS'(1) << p[4:0];
    return (p < PIDX_BITS'(32)) ? bit_word : ~bit_word;
  endfunction

endpackage

/* rtl/trpt_item_if.sv */
// ----------------------------------------------------------------------------
// trpt_item_if
// Input channel: test tick or returned read word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trpt_item_if import trpt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [DATA_BITS-1:0] read_data;

  modport source (output valid, cmd, read_data, input ready);
  modport sink   (input valid, cmd, read_data, output ready);
endinterface

/* rtl/trpt_result_if.sv */
// ----------------------------------------------------------------------------
// trpt_result_if
// Result channel: memory requests and step status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trpt_result_if import trpt_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_BITS-1:0] write_data;
  logic                 last;

  modport source (output valid, kind, address, write_data, last, input ready);
  modport sink   (input valid, kind, address, write_data, last, output ready);
endinterface

/* rtl/transparent_ram_pair_pattern_test.sv */
// ----------------------------------------------------------------------------
// transparent_ram_pair_pattern_test
// Transparent walking-one / walking-zero test of word pairs in an external RAM.
// ----------------------------------------------------------------------------
// Results of an item are registered and appear in the cycle after its transfer.
// Throughput: one item per cycle while the output is ready and no item has
//   more than one result; else input waits while the 3-entry buffer drains.
// Reset (rst, synchronous): idle phase, not halted, empty result buffer,
//   region is the whole address space.
module transparent_ram_pair_pattern_test import trpt_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ADDR_BITS:0]   cfg_data,
  trpt_item_if.sink            item,
  trpt_result_if.source        result
);

  localparam int PW = ADDR_BITS + 1;  // pointer width, one bit past the region

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] data;
    logic                 last;
  } res_t;

  // Result entry: address only on requests, data only on writes.
  function automatic res_t mk_res(input kind_t k, input logic [PW-1:0] a,
                                  input logic [DATA_BITS-1:0] d);
    res_t r;
    r.kind    = k;
    r.address = (k == KIND_READ || k == KIND_WRITE) ? a[ADDR_BITS-1:0] : '0;
    r.data    = (k == KIND_WRITE) ? d : '0;
    r.last    = 1'b0;
    return r;
  endfunction

  // Configuration
  logic [ADDR_BITS-1:0] region_start;
  logic [PW-1:0]        ram_end;

  // Sequencer state
  logic [PW-1:0]        cell_addr, cell_addr_next;
  logic [PW-1:0]        base_addr, base_addr_next;
  logic [PIDX_BITS-1:0] pattern_index, pattern_index_next;
  phase_t               phase, phase_next;
  logic [DATA_BITS-1:0] base_saved, base_saved_next;
  logic [DATA_BITS-1:0] cell_saved, cell_saved_next;
  logic                 halted, halted_next;

  // Result buffer: entry 0 drives the output
  res_t       res_buf [3];
  res_t       res_new [3];
  logic [1:0] res_count;
  logic [1:0] res_n;

  logic item_xfer, result_xfer;

  // Pointer arithmetic
  logic                 cell_in;
  logic [PW-1:0]        base_inc, cell_inc, cell_inc2, start_inc;
  logic                 base_below, cinc_below;
  logic [DATA_BITS-1:0] bg, pw_word;

  assign result_xfer = result.valid && result.ready;
  // Take a new item when the buffer is empty or its final entry leaves now.
  assign item.ready  = (res_count == 2'd0) || (res_count == 2'd1 && result.ready);
  assign item_xfer   = item.valid && item.ready;

  assign result.valid      = (res_count != 2'd0);
  assign result.kind       = res_buf[0].kind;
  assign result.address    = res_buf[0].address;
  assign result.write_data = res_buf[0].data;
  assign result.last       = res_buf[0].last;

  assign cell_in   = cell_addr < ram_end;
  assign base_inc  = base_addr + PW'(1);
  assign cell_inc  = cell_addr + PW'(1);
  assign cell_inc2 = cell_inc + PW'(1);
  assign start_inc = {1'b0, region_start} + PW'(1);
  // "x < ram_end - 1" with the end of zero wrapping to the largest value
  assign base_below = (ram_end == '0) ||
                      (({1'b0, base_addr} + (PW+1)'(1)) < {1'b0, ram_end});
  assign cinc_below = (ram_end == '0) ||
                      (({1'b0, cell_inc} + (PW+1)'(1)) < {1'b0, ram_end});
  assign bg      = background_word(pattern_index);
  assign pw_word = pattern_word(pattern_index);

  always_comb begin
    cell_addr_next     = cell_addr;
    base_addr_next     = base_addr;
    pattern_index_next = pattern_index;
    phase_next         = phase;
    base_saved_next    = base_saved;
    cell_saved_next    = cell_saved;
    halted_next        = halted;
    res_n              = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res_new[i] = mk_res(KIND_DONE, '0, '0);
    end

    if (halted) begin
      res_new[0] = mk_res(KIND_ERROR, '0, '0);
      res_n      = 2'd1;
    end else if (!item.cmd) begin
      // Tick: start a step, or move the pointers; ignored mid-step
      if (phase == PH_IDLE) begin
        if (cell_in && base_addr != cell_addr &&
            pattern_index < PIDX_BITS'(PATTERN_COUNT)) begin
          res_new[0] = mk_res(KIND_READ, base_addr, '0);
          res_new[1] = mk_res(KIND_READ, cell_addr, '0);
          res_n      = 2'd2;
          phase_next = PH_SAVE_BASE;
        end else begin
          if (!cell_in) begin
            cell_addr_next = {1'b0, region_start};
            base_addr_next = start_inc;
          end else if (base_addr != cell_addr) begin
            pattern_index_next = '0;
            base_addr_next     = base_below ? base_inc : {1'b0, region_start};
          end else begin
            cell_addr_next = cell_inc;
            base_addr_next = cinc_below ? cell_inc2 : {1'b0, region_start};
          end
          res_new[0] = mk_res(KIND_DONE, '0, '0);
          res_n      = 2'd1;
        end
      end
    end else begin
      // Returned read word
      case (phase)
        PH_SAVE_BASE: begin
          base_saved_next = item.read_data;
          phase_next      = PH_SAVE_CELL;
        end
        PH_SAVE_CELL: begin
          cell_saved_next = item.read_data;
          res_new[0]      = mk_res(KIND_WRITE, base_addr, bg);
          res_new[1]      = mk_res(KIND_WRITE, cell_addr, pw_word);
          res_new[2]      = mk_res(KIND_READ, base_addr, '0);
          res_n           = 2'd3;
          phase_next      = PH_CHECK_BASE;
        end
        PH_CHECK_BASE: begin
          if (item.read_data != bg) begin
            halted_next = 1'b1;
            phase_next  = PH_IDLE;
            res_new[0]  = mk_res(KIND_ERROR, '0, '0);
          end else begin
            phase_next  = PH_CHECK_CELL;
            res_new[0]  = mk_res(KIND_READ, cell_addr, '0);
          end
          res_n = 2'd1;
        end
        PH_CHECK_CELL: begin
          if (item.read_data != pw_word) begin
            halted_next = 1'b1;
            res_new[0]  = mk_res(KIND_ERROR, '0, '0);
            res_n       = 2'd1;
          end else begin
            // Restore the saved words, step done
            res_new[0]         = mk_res(KIND_WRITE, base_addr, base_saved);
            res_new[1]         = mk_res(KIND_WRITE, cell_addr, cell_saved);
            res_new[2]         = mk_res(KIND_DONE, '0, '0);
            res_n              = 2'd3;
            pattern_index_next = pattern_index + PIDX_BITS'(1);
          end
          phase_next = PH_IDLE;
        end
        default: begin
          // data while idle: dropped
        end
      endcase
    end

    for (int i = 0; i < 3; i++) begin
      res_new[i].last = (res_n != 2'd0) && (2'(i) == res_n - 2'd1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      ram_end      <= PW'(1) << ADDR_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_START: region_start <= cfg_data[ADDR_BITS-1:0];
        REG_RAM_END:   ram_end      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, updated on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_addr     <= '1;
      base_addr     <= '0;
      pattern_index <= '0;
      phase         <= PH_IDLE;
      base_saved    <= '0;
      cell_saved    <= '0;
      halted        <= 1'b0;
    end else if (item_xfer) begin
      cell_addr     <= cell_addr_next;
      base_addr     <= base_addr_next;
      pattern_index <= pattern_index_next;
      phase         <= phase_next;
      base_saved    <= base_saved_next;
      cell_saved    <= cell_saved_next;
      halted        <= halted_next;
    end
  end

  // Result buffer: load on item transfer, else shift out on result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
    end else if (item_xfer) begin
      res_count <= res_n;
    end else if (result_xfer) begin
      res_count <= res_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      res_buf <= res_new;
    end else if (result_xfer) begin
      res_buf[0] <= res_buf[1];
      res_buf[1] <= res_buf[2];
    end
  end

endmodule
